/* sv/square_matrix_rotate_90_defines.svh */
// assertion macros for the square matrix rotator checker
// used by smr90_checker; no other dependencies
`ifndef SQUARE_MATRIX_ROTATE_90_DEFINES_SVH
`define SQUARE_MATRIX_ROTATE_90_DEFINES_SVH

// property that must hold at every clock edge outside reset
`define SMR90_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// implication checked in the cycle after the antecedent
`define SMR90_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* sv/smr90_pkg.sv */
// shared constants, codes and types of the square matrix rotator
// no dependencies; used by smr90_rot_seq, the top level and the checker
package smr90_pkg;

  // built sizes
  localparam int MAX_SIDE      = 16;
  localparam int ELEMENT_WIDTH = 32;
  localparam int CELLS         = MAX_SIDE * MAX_SIDE;
  localparam int POS_W         = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int TOTAL_W       = $clog2(CELLS + 1);
  localparam int ROW_W         = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
  localparam int SIDE_W        = $clog2(MAX_SIDE + 1);
  localparam int CFG_W         = 5;
  localparam int ACT_W         = 2;

  // action codes carried on tuser
  localparam logic [ACT_W-1:0] ACT_LOAD   = 2'd0;
  localparam logic [ACT_W-1:0] ACT_ROTATE = 2'd1;
  localparam logic [ACT_W-1:0] ACT_READ   = 2'd2;

  // reset value of the size register
  localparam logic [CFG_W-1:0] SIZE_RESET = 5'd4;

  // top level control
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_ROT
  } top_state_t;

  // rotation sequencer: four reads then four writes per swap
  typedef enum logic [3:0] {
    ROT_IDLE,
    ROT_RA,
    ROT_RB,
    ROT_RC,
    ROT_RD,
    ROT_WD,
    ROT_WC,
    ROT_WB,
    ROT_WA
  } rot_state_t;

  // which buffered corner feeds the write port
  typedef enum logic [1:0] {
    SEL_A,
    SEL_B,
    SEL_C,
    SEL_D
  } data_sel_t;

  // commands from the sequencer to the datapath
  typedef struct packed {
    logic             busy;
    logic             rd_en;
    logic             wr_en;
    logic             lat_a;
    logic             lat_b;
    logic             lat_c;
    data_sel_t        wsel;
    logic [ROW_W-1:0] row;
    logic [ROW_W-1:0] col;
  } rot_cmd_t;

endpackage

/* sv/smr90_rot_seq.sv */
// rotation sequencer: walks rings and four-way swaps of the stored matrix
// depends on smr90_pkg; drives the shared address unit and memory port in the top
module smr90_rot_seq (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [smr90_pkg::SIDE_W-1:0] side,
  output smr90_pkg::rot_cmd_t          cmd
);

  localparam int SW = smr90_pkg::SIDE_W;
  localparam int RW = smr90_pkg::ROW_W;

  smr90_pkg::rot_state_t state, state_next;
  logic [RW-1:0] ring, ring_next;
  logic [RW-1:0] k, k_next;

  logic [SW-1:0] ring_x, k_x, far_x, opp_x, half_x;
  logic [RW-1:0] far_r, opp_r;

  // ring geometry
  always_comb begin
    ring_x = SW'(ring);
    k_x    = SW'(k);
    far_x  = side - SW'(1) - ring_x;
    opp_x  = side - SW'(1) - k_x;
    half_x = side >> 1;
    far_r  = RW'(far_x);
    opp_r  = RW'(opp_x);
  end

  // state and loop registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= smr90_pkg::ROT_IDLE;
      ring  <= '0;
      k     <= '0;
    end else begin
      state <= state_next;
      ring  <= ring_next;
      k     <= k_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    ring_next  = ring;
    k_next     = k;
    cmd        = '0;
    cmd.wsel   = smr90_pkg::SEL_A;
    cmd.busy   = (state != smr90_pkg::ROT_IDLE);
    case (state)
      smr90_pkg::ROT_IDLE: begin
        if (start) begin
          ring_next  = '0;
          k_next     = '0;
          state_next = smr90_pkg::ROT_RA;
        end
      end
      smr90_pkg::ROT_RA: begin
        cmd.rd_en  = 1'b1;
        cmd.row    = ring;
        cmd.col    = k;
        state_next = smr90_pkg::ROT_RB;
      end
      smr90_pkg::ROT_RB: begin
        cmd.rd_en  = 1'b1;
        cmd.lat_a  = 1'b1;
        cmd.row    = k;
        cmd.col    = far_r;
        state_next = smr90_pkg::ROT_RC;
      end
      smr90_pkg::ROT_RC: begin
        cmd.rd_en  = 1'b1;
        cmd.lat_b  = 1'b1;
        cmd.row    = far_r;
        cmd.col    = opp_r;
        state_next = smr90_pkg::ROT_RD;
      end
      smr90_pkg::ROT_RD: begin
        cmd.rd_en  = 1'b1;
        cmd.lat_c  = 1'b1;
        cmd.row    = opp_r;
        cmd.col    = ring;
        state_next = smr90_pkg::ROT_WD;
      end
      smr90_pkg::ROT_WD: begin
        cmd.wr_en  = 1'b1;
        cmd.wsel   = smr90_pkg::SEL_C;
        cmd.row    = opp_r;
        cmd.col    = ring;
        state_next = smr90_pkg::ROT_WC;
      end
      smr90_pkg::ROT_WC: begin
        cmd.wr_en  = 1'b1;
        cmd.wsel   = smr90_pkg::SEL_B;
        cmd.row    = far_r;
        cmd.col    = opp_r;
        state_next = smr90_pkg::ROT_WB;
      end
      smr90_pkg::ROT_WB: begin
        cmd.wr_en  = 1'b1;
        cmd.wsel   = smr90_pkg::SEL_A;
        cmd.row    = k;
        cmd.col    = far_r;
        state_next = smr90_pkg::ROT_WA;
      end
      smr90_pkg::ROT_WA: begin
        cmd.wr_en = 1'b1;
        cmd.wsel  = smr90_pkg::SEL_D;
        cmd.row   = ring;
        cmd.col   = k;
        // step along the ring, then inward, then finish
        if (k_x + SW'(1) < far_x) begin
          k_next     = k + RW'(1);
          state_next = smr90_pkg::ROT_RA;
        end else if (ring_x + SW'(1) < half_x) begin
          ring_next  = ring + RW'(1);
          k_next     = ring + RW'(1);
          state_next = smr90_pkg::ROT_RA;
        end else begin
          state_next = smr90_pkg::ROT_IDLE;
        end
      end
      default: begin
        state_next = smr90_pkg::ROT_IDLE;
      end
    endcase
  end

endmodule

/* sv/square_matrix_rotate_90.sv */
// square matrix rotator: loads may follow back to back;
// a read holds the input side until the output register is free, and its result
// passes through the registered store read and the output register.
// a rotate of side n keeps the input side busy through its swaps (one memory port,
// four reads and four writes per four-way swap); a rotate of side 1 does not busy it.
// reset: synchronous, clears positions, output valid and size (to 4); store not cleared.
module square_matrix_rotate_90 (
  input  logic                                  clk,
  input  logic                                  rst,
  // input stream
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  logic [31:0]                           s_axis_tdata,   // [31:0] element_value
  input  logic [1:0]                            s_axis_tuser,   // [1:0] action
  // output stream
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  output logic [31:0]                           m_axis_tdata,   // [31:0] element_out
  output logic                                  m_axis_tlast,   // last_element
  // size register write
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [smr90_pkg::CFG_W-1:0]           cfg_data
);

  localparam int EW = smr90_pkg::ELEMENT_WIDTH;
  localparam int PW = smr90_pkg::POS_W;
  localparam int TW = smr90_pkg::TOTAL_W;
  localparam int SW = smr90_pkg::SIDE_W;
  localparam int RW = smr90_pkg::ROW_W;

  smr90_pkg::top_state_t state, state_next;
  smr90_pkg::rot_cmd_t   cmd;

  logic [smr90_pkg::CFG_W-1:0] matrix_size;
  logic [PW-1:0] load_pos, load_pos_next;
  logic [PW-1:0] read_pos, read_pos_next;
  logic [PW-1:0] load_eff, read_eff;
  logic [SW-1:0] side;
  logic [TW-1:0] total;

  logic [EW-1:0] mem [smr90_pkg::CELLS];
  logic [EW-1:0] rd_data;
  logic [EW-1:0] va, vb, vc;
  logic [EW-1:0] wdata;
  logic [PW-1:0] addr;
  logic [PW-1:0] rot_addr;
  logic [RW+SW-1:0] prod;
  logic          wr_en, rd_en;

  logic          accept;
  logic          is_load, is_rot, is_read;
  logic          start_rot;
  logic          last_pend;
  logic          out_free;
  logic          out_valid;
  logic [EW-1:0] out_data;
  logic          out_last;

  // size register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      matrix_size <= smr90_pkg::SIZE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      matrix_size <= cfg_data;
    end
  end

  // side in use, clamped to 1..MAX_SIDE
  always_comb begin
    if (matrix_size == '0) begin
      side = SW'(1);
    end else if (int'(matrix_size) > smr90_pkg::MAX_SIDE) begin
      side = SW'(smr90_pkg::MAX_SIDE);
    end else begin
      side = SW'(matrix_size);
    end
    total = TW'(side) * TW'(side);
  end

  // input decode
  assign s_axis_tready = (state == smr90_pkg::ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign is_load       = accept && (s_axis_tuser == smr90_pkg::ACT_LOAD);
  assign is_rot        = accept && (s_axis_tuser == smr90_pkg::ACT_ROTATE);
  assign is_read       = accept && (s_axis_tuser == smr90_pkg::ACT_READ);
  assign start_rot     = is_rot && (side > SW'(1));

  // stale positions fall back to zero, then wrap on advance
  always_comb begin
    load_eff      = (TW'(load_pos) >= total) ? '0 : load_pos;
    read_eff      = (TW'(read_pos) >= total) ? '0 : read_pos;
    load_pos_next = load_pos;
    read_pos_next = read_pos;
    if (is_load) begin
      load_pos_next = (TW'(load_eff) + TW'(1) >= total) ? '0 : load_eff + PW'(1);
    end
    if (is_rot) begin
      read_pos_next = '0;
    end else if (is_read) begin
      read_pos_next = (TW'(read_eff) + TW'(1) >= total) ? '0 : read_eff + PW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      load_pos <= '0;
      read_pos <= '0;
    end else begin
      load_pos <= load_pos_next;
      read_pos <= read_pos_next;
    end
  end

  // rotation sequencer
  smr90_rot_seq u_rot_seq (
    .clk   (clk),
    .rst   (rst),
    .start (start_rot),
    .side  (side),
    .cmd   (cmd)
  );

  // shared address unit: row * side + col
  always_comb begin
    prod     = (RW+SW)'(cmd.row) * (RW+SW)'(side) + (RW+SW)'(cmd.col);
    rot_addr = PW'(prod);
  end

  // memory port control
  always_comb begin
    rd_en = is_read || cmd.rd_en;
    wr_en = is_load || cmd.wr_en;
    if (cmd.busy) begin
      addr = rot_addr;
    end else if (is_load) begin
      addr = load_eff;
    end else begin
      addr = read_eff;
    end
    case (cmd.wsel)
      smr90_pkg::SEL_A: wdata = va;
      smr90_pkg::SEL_B: wdata = vb;
      smr90_pkg::SEL_C: wdata = vc;
      smr90_pkg::SEL_D: wdata = rd_data;
      default:          wdata = rd_data;
    endcase
    if (!cmd.busy) begin
      wdata = s_axis_tdata[EW-1:0];
    end
  end

  // element store, registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[addr] <= wdata;
    end
    if (rd_en) begin
      rd_data <= mem[addr];
    end
  end

  // corner buffers for the four-way swap
  always_ff @(posedge clk) begin
    if (cmd.lat_a) begin
      va <= rd_data;
    end
    if (cmd.lat_b) begin
      vb <= rd_data;
    end
    if (cmd.lat_c) begin
      vc <= rd_data;
    end
    if (is_read) begin
      last_pend <= (TW'(read_eff) + TW'(1) == total);
    end
  end

  // control state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= smr90_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next control state
  assign out_free = !out_valid || m_axis_tready;

  always_comb begin
    state_next = state;
    case (state)
      smr90_pkg::ST_IDLE: begin
        if (is_read) begin
          state_next = smr90_pkg::ST_READ;
        end else if (start_rot) begin
          state_next = smr90_pkg::ST_ROT;
        end
      end
      smr90_pkg::ST_READ: begin
        if (out_free) begin
          state_next = smr90_pkg::ST_IDLE;
        end
      end
      smr90_pkg::ST_ROT: begin
        if (!cmd.busy) begin
          state_next = smr90_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = smr90_pkg::ST_IDLE;
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == smr90_pkg::ST_READ && out_free) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == smr90_pkg::ST_READ && out_free) begin
      out_data <= rd_data;
      out_last <= last_pend;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;
  assign m_axis_tlast  = out_last;

endmodule

/* sv/smr90_checker.sv */
// port-level checker for the square matrix rotator, bound to the top level
// depends on smr90_pkg and square_matrix_rotate_90_defines.svh
`include "square_matrix_rotate_90_defines.svh"

module smr90_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        s_axis_tvalid,
  input logic                        s_axis_tready,
  input logic [1:0]                  s_axis_tuser,
  input logic                        m_axis_tvalid,
  input logic                        m_axis_tready,
  input logic [31:0]                 m_axis_tdata,
  input logic                        m_axis_tlast,
  input logic                        cfg_valid,
  input logic                        cfg_ready
);

  logic in_xfer;
  logic load_xfer;
  logic read_xfer;

  assign in_xfer   = s_axis_tvalid && s_axis_tready;
  assign load_xfer = in_xfer && (s_axis_tuser == smr90_pkg::ACT_LOAD);
  assign read_xfer = in_xfer && (s_axis_tuser == smr90_pkg::ACT_READ);

  // a stalled result holds its payload
  `SMR90_ASSERT_NEXT(a_out_hold, clk, rst, m_axis_tvalid && !m_axis_tready,
    m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast), "stalled result changed")

  // a read transfer keeps the input side busy while the store is read
  `SMR90_ASSERT_NEXT(a_read_busy, clk, rst, read_xfer, !s_axis_tready,
    "input ready right after a read transfer")

  // a load never stalls the input side
  `SMR90_ASSERT_NEXT(a_load_ready, clk, rst, load_xfer, s_axis_tready,
    "input stalled after a load transfer")

  // a load never produces a result
  `SMR90_ASSERT_NEXT(a_load_quiet, clk, rst, load_xfer && !m_axis_tvalid, !m_axis_tvalid,
    "result appeared after a load transfer")

  // configuration port never stalls
  `SMR90_ASSERT(a_cfg_ready, clk, rst, cfg_ready || !cfg_valid, "configuration write stalled")

endmodule

bind square_matrix_rotate_90 smr90_checker u_smr90_checker (.*);

/* tb/tb_top.sv */
// self-checking testbench for square_matrix_rotate_90: directed table, a back-pressure
// burst, then random load/rotate/read traffic; directed reads are checked against pinned
// values, others against an in-bench matrix tracker; depends on smr90_pkg and the rtl
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ACT_W         = smr90_pkg::ACT_W;
  localparam int ELEMENT_WIDTH = smr90_pkg::ELEMENT_WIDTH;
  localparam int CFG_W         = smr90_pkg::CFG_W;
  localparam int CELLS         = smr90_pkg::CELLS;
  localparam int MAX_SIDE      = smr90_pkg::MAX_SIDE;

  localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;
  localparam logic [ELEMENT_WIDTH-1:0] ELEM_MAX     = 32'h7FFF_FFFF;
  localparam logic [ELEMENT_WIDTH-1:0] ELEM_MIN     = 32'h8000_0000;
  localparam logic [ELEMENT_WIDTH-1:0] ELEM_NEG_ONE = 32'hFFFF_FFFF;
  localparam logic [ELEMENT_WIDTH-1:0] ELEM_ZERO    = 32'h0000_0000;
  localparam logic [ELEMENT_WIDTH-1:0] ELEM_STRIPE  = 32'hA5A5_A5A5;
  localparam int RANDOM_ITEMS    = 1750;
  localparam int IDLE_LIMIT      = 4000;
  // wait past the longest rotate before touching the size register
  localparam int SETTLE_CYCLES   = 600;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int CHOKE_READS     = 60;
  localparam int DRAIN_CYCLES    = 32;

  typedef struct {
    logic [ELEMENT_WIDTH-1:0] element;
    logic                     last;
  } read_result_t;

  typedef struct {
    bit                       write_side;
    logic [CFG_W-1:0]         side_value;
    logic [ACT_W-1:0]         act;
    logic [ELEMENT_WIDTH-1:0] value;
    bit                       pinned;
    read_result_t             pin;
  } step_row_t;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     s_axis_tvalid = 1'b0;
  logic                     s_axis_tready;
  logic [ELEMENT_WIDTH-1:0] s_axis_tdata = '0;   // [31:0] element_value
  logic [ACT_W-1:0]         s_axis_tuser = smr90_pkg::ACT_LOAD; // [1:0] action
  logic                     m_axis_tvalid;
  logic                     m_axis_tready = 1'b0;
  logic [ELEMENT_WIDTH-1:0] m_axis_tdata;        // [31:0] element_out
  logic                     m_axis_tlast;        // last_element
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic [CFG_W-1:0]         cfg_data = '0;

  // matrix tracker state
  logic [ELEMENT_WIDTH-1:0] shadow_cells [CELLS];
  bit                       cell_loaded [CELLS];
  int unsigned              fill_pos = 0;
  int unsigned              fetch_pos = 0;
  logic [CFG_W-1:0]         side_reg = smr90_pkg::SIZE_RESET;

  read_result_t pending_reads [$];
  step_row_t    directed_rows [$];
  read_result_t unpinned;
  int           errors = 0;
  int           idle_cycles = 0;
  int           random_items = 0;
  bit           calm = 0;
  bit           choke_request = 0;

  square_matrix_rotate_90 dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data)
  );

  // clock
  initial begin
    forever #2 clk = ~clk;
  end

  // side length actually used for a register value
  function automatic int unsigned active_side();
    if (side_reg == 0) return 1;
    if (side_reg > MAX_SIDE) return MAX_SIDE;
    return 32'(side_reg);
  endfunction

  // clockwise quarter turn, four corners per step, loaded flags follow the data
  function automatic void turn_matrix(int unsigned n);
    int unsigned far, opp, a, b, c, d;
    logic [ELEMENT_WIDTH-1:0] held;
    bit held_flag;
    for (int unsigned ring = 0; ring < n / 2; ring++) begin
      far = n - 1 - ring;
      for (int unsigned k = ring; k < far; k++) begin
        opp = n - 1 - k;
        a = ring * n + k;
        b = k * n + far;
        c = far * n + opp;
        d = opp * n + ring;
        held = shadow_cells[d];
        shadow_cells[d] = shadow_cells[c];
        shadow_cells[c] = shadow_cells[b];
        shadow_cells[b] = shadow_cells[a];
        shadow_cells[a] = held;
        held_flag = cell_loaded[d];
        cell_loaded[d] = cell_loaded[c];
        cell_loaded[c] = cell_loaded[b];
        cell_loaded[b] = cell_loaded[a];
        cell_loaded[a] = held_flag;
      end
    end
  endfunction

  // advance the tracker by one accepted item, return 1 when it yields a result
  function automatic bit step_matrix(input logic [ACT_W-1:0] act,
                                     input logic [ELEMENT_WIDTH-1:0] val,
                                     output read_result_t res);
    int unsigned n, total;
    n = active_side();
    total = n * n;
    res.element = '0;
    res.last = 1'b0;
    // positions left over from a larger side restart at zero
    if (fill_pos >= total) fill_pos = 0;
    if (fetch_pos >= total) fetch_pos = 0;
    case (act)
      smr90_pkg::ACT_LOAD: begin
        shadow_cells[fill_pos] = val;
        cell_loaded[fill_pos] = 1'b1;
        fill_pos = (fill_pos + 1 >= total) ? 0 : fill_pos + 1;
      end
      smr90_pkg::ACT_ROTATE: begin
        turn_matrix(n);
        fetch_pos = 0;
      end
      smr90_pkg::ACT_READ: begin
        res.element = shadow_cells[fetch_pos];
        res.last = (fetch_pos == total - 1);
        fetch_pos = (fetch_pos + 1 >= total) ? 0 : fetch_pos + 1;
        return 1'b1;
      end
      default: begin
      end
    endcase
    return 1'b0;
  endfunction

  // a read may only touch an entry that has been loaded
  function automatic bit read_is_safe();
    int unsigned n;
    n = active_side();
    return cell_loaded[(fetch_pos >= n * n) ? 0 : fetch_pos];
  endfunction

  // mostly no gap, some short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [ELEMENT_WIDTH-1:0] rand_element();
    int r;
    r = $urandom_range(0, 99);
    if (r < 5) return ELEM_MIN;
    if (r < 10) return ELEM_MAX;
    return $urandom;
  endfunction

  // table builders
  function automatic void add_side(logic [CFG_W-1:0] v);
    step_row_t row;
    row.write_side = 1;
    row.side_value = v;
    row.act = ACT_UNUSED;
    row.value = '0;
    row.pinned = 0;
    row.pin = unpinned;
    directed_rows.push_back(row);
  endfunction

  function automatic void add_op(logic [ACT_W-1:0] act, logic [ELEMENT_WIDTH-1:0] val);
    step_row_t row;
    row.write_side = 0;
    row.side_value = '0;
    row.act = act;
    row.value = val;
    row.pinned = 0;
    row.pin = unpinned;
    directed_rows.push_back(row);
  endfunction

  function automatic void add_read(logic [ELEMENT_WIDTH-1:0] elem, logic last);
    step_row_t row;
    row.write_side = 0;
    row.side_value = '0;
    row.act = smr90_pkg::ACT_READ;
    row.value = ELEM_ZERO;
    row.pinned = 1;
    row.pin.element = elem;
    row.pin.last = last;
    directed_rows.push_back(row);
  endfunction

  // one input transfer, then update the tracker and queue any result
  task automatic send_op(input logic [ACT_W-1:0] act, input logic [ELEMENT_WIDTH-1:0] val,
                         input bit eager, input bit pinned, input read_result_t pin);
    int gap;
    read_result_t res;
    gap = (eager || calm) ? 0 : pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      s_axis_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= act;
    s_axis_tdata <= val;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    if (step_matrix(act, val, res)) begin
      if (pinned) begin
        pending_reads.push_back(pin);
      end else begin
        pending_reads.push_back(res);
      end
    end
  endtask

  // size register write, only once the block has gone quiet
  task automatic write_side(input logic [CFG_W-1:0] v);
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    wait (pending_reads.size() == 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    side_reg = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // receiver stalls, with one long hold-off on request
  initial begin
    int stall;
    forever begin
      @(negedge clk);
      if (choke_request) begin
        choke_request = 0;
        m_axis_tready <= 1'b0;
        repeat (HOLD_OFF_CYCLES - 1) @(negedge clk);
      end else if (calm) begin
        m_axis_tready <= 1'b1;
      end else begin
        stall = pick_gap();
        if (stall == 0) begin
          m_axis_tready <= 1'b1;
        end else begin
          m_axis_tready <= 1'b0;
          repeat (stall - 1) @(negedge clk);
        end
      end
    end
  end

  // result check against the oldest expectation
  always @(posedge clk) begin
    read_result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_reads.size() == 0) begin
        $display("%0t: unexpected result element=%h last=%b", $time, m_axis_tdata,
                 m_axis_tlast);
        errors++;
      end else begin
        want = pending_reads.pop_front();
        if (m_axis_tdata !== want.element) begin
          $display("%0t: element mismatch expected=%h actual=%h", $time, want.element,
                   m_axis_tdata);
          errors++;
        end
        if (m_axis_tlast !== want.last) begin
          $display("%0t: last flag mismatch expected=%b actual=%b", $time, want.last,
                   m_axis_tlast);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles with no transfer anywhere
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // stimulus
  initial begin
    int unsigned n, count;
    int r;
    logic [ACT_W-1:0] act;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // side 2: extremes, read back, turn, read back, unused action, wrap
    add_side(5'd2);
    add_op(smr90_pkg::ACT_LOAD, ELEM_MAX);
    add_op(smr90_pkg::ACT_LOAD, ELEM_MIN);
    add_op(smr90_pkg::ACT_LOAD, ELEM_NEG_ONE);
    add_op(smr90_pkg::ACT_LOAD, ELEM_ZERO);
    add_read(ELEM_MAX, 1'b0);
    add_read(ELEM_MIN, 1'b0);
    add_read(ELEM_NEG_ONE, 1'b0);
    add_read(ELEM_ZERO, 1'b1);
    add_op(smr90_pkg::ACT_ROTATE, ELEM_ZERO);
    add_read(ELEM_NEG_ONE, 1'b0);
    add_read(ELEM_MAX, 1'b0);
    add_read(ELEM_ZERO, 1'b0);
    add_read(ELEM_MIN, 1'b1);
    add_op(ACT_UNUSED, 32'h5555_5555);
    add_read(ELEM_NEG_ONE, 1'b0);
    // side 1: stale positions restart, a turn changes nothing
    add_side(5'd1);
    add_op(smr90_pkg::ACT_LOAD, ELEM_STRIPE);
    add_op(smr90_pkg::ACT_ROTATE, ELEM_NEG_ONE);
    add_read(ELEM_STRIPE, 1'b1);
    add_read(ELEM_STRIPE, 1'b1);
    // zero size behaves as side 1
    add_side(5'd0);
    add_read(ELEM_STRIPE, 1'b1);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].write_side) begin
        write_side(directed_rows[i].side_value);
      end else begin
        send_op(directed_rows[i].act, directed_rows[i].value, 1'b0, directed_rows[i].pinned,
                directed_rows[i].pin);
      end
    end

    // back pressure: reads pile up while the receiver holds off
    write_side(5'd4);
    repeat (16) send_op(smr90_pkg::ACT_LOAD, rand_element(), 1'b0, 1'b0, unpinned);
    choke_request = 1;
    repeat (CHOKE_READS) send_op(smr90_pkg::ACT_READ, rand_element(), 1'b1, 1'b0, unpinned);

    // random phases: new side, fill the matrix (sometimes only partly), then mixed traffic
    while (random_items < RANDOM_ITEMS) begin
      calm = 0;
      r = $urandom_range(0, 99);
      if (r < 8) begin
        case ($urandom_range(0, 3))
          0: write_side(5'd0);
          1: write_side(5'd16);
          2: write_side(5'd17);
          default: write_side(5'd31);
        endcase
      end else if (r < 20) begin
        write_side(CFG_W'($urandom_range(7, 15)));
      end else begin
        write_side(CFG_W'($urandom_range(1, 6)));
      end
      calm = ($urandom_range(0, 3) == 0);
      n = active_side();
      count = ($urandom_range(0, 4) == 0) ? $urandom_range(0, n * n - 1) : n * n;
      repeat (count) begin
        send_op(smr90_pkg::ACT_LOAD, rand_element(), 1'b0, 1'b0, unpinned);
        random_items++;
      end
      count = (n > 8) ? $urandom_range(20, 80) : $urandom_range(10, 60);
      repeat (count) begin
        r = $urandom_range(0, 99);
        if (r < 40) act = smr90_pkg::ACT_READ;
        else if (r < 52) act = smr90_pkg::ACT_ROTATE;
        else if (r < 94) act = smr90_pkg::ACT_LOAD;
        else act = ACT_UNUSED;
        // never read an entry that was not loaded
        if (act == smr90_pkg::ACT_READ && !read_is_safe()) act = smr90_pkg::ACT_LOAD;
        send_op(act, rand_element(), 1'b0, 1'b0, unpinned);
        if (act != ACT_UNUSED) random_items++;
      end
    end
    calm = 0;

    // drain and report
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    wait (pending_reads.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+sv
sv/smr90_pkg.sv
sv/smr90_rot_seq.sv
sv/square_matrix_rotate_90.sv
sv/smr90_checker.sv
tb/tb_top.sv
